// File: rtl/mspwm_pkg.sv
// Package for the multichannel soft-PWM driver: widths, codes, shared types.
// No dependencies.
package mspwm_pkg;
  localparam int CHANNELS = 32;
  localparam int CH_W = $clog2(CHANNELS);
  localparam int NBANKS = (CHANNELS + 7) / 8;
  localparam logic [7:0] STATE_MARK = 8'd64;
  localparam logic [5:0] FULL_LEVEL = 6'd49;
  localparam logic [7:0] MODE_TRI = 8'd129;
  localparam logic [7:0] MODE_SQR = 8'd130;
  localparam logic [7:0] MODE_FALL = 8'd131;
  localparam logic [7:0] MODE_RISE = 8'd132;
  localparam logic [2:0] REG_PERIOD = 3'd0;
  localparam logic [2:0] REG_OFF_AT = 3'd1;
  localparam logic [2:0] REG_INVERT = 3'd2;
  localparam logic [2:0] REG_NIGHT = 3'd3;
  localparam logic [2:0] REG_SAFE_MASK = 3'd4;
  localparam logic [2:0] REG_SAFE_LIM = 3'd5;

  // queued word between front and back
  typedef struct packed {
    logic       is_tick;
    logic       night;
    logic [63:0] bytes;
  } item_t;

  // level for one mode and phase (enable/night handled by caller)
  function automatic logic [5:0] mode_level(input logic [7:0] m, input logic [15:0] ph);
    logic [7:0] x;
    logic [13:0] p;
    mode_level = 6'd0;
    x = ph[15:8];
    p = 14'd0;
    if (m <= 8'd49) mode_level = m[5:0];
    else begin
      unique case (m)
        MODE_TRI: begin
          if (x[7]) x = 8'd255 - x;
          p = 14'd49 * {6'd0, x};
          mode_level = p[12:7];
        end
        MODE_SQR: mode_level = ph[15] ? FULL_LEVEL : 6'd0;
        MODE_FALL: begin
          p = 14'd49 * {6'd0, 8'd255 - x};
          mode_level = p[13:8];
        end
        MODE_RISE: begin
          p = 14'd49 * {6'd0, x};
          mode_level = p[13:8];
        end
        default: mode_level = 6'd0;
      endcase
    end
  endfunction
endpackage

// File: rtl/mspwm_front.sv
// Front end: takes input words and pushes them into a two-entry queue.
// Depends on mspwm_pkg.
module mspwm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  input  logic                pop,
  output logic                q_valid,
  output mspwm_pkg::item_t    q_item
);
  import mspwm_pkg::*;
  item_t mem_r [2];
  logic rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = mem_r[rd_r];

  always_comb begin
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // tuser bit 0 is the opcode, bit 1 the night switch
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= '{is_tick: in_tuser[0], night: in_tuser[1], bytes: in_tdata};
    if (!rst_n) begin
      rd_r <= 1'b0; wr_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      rd_r <= rd_nxt; wr_r <= wr_nxt; cnt_r <= cnt_nxt;
    end
  end
endmodule

// File: rtl/mspwm_back.sv
// Back end: carries out messages and ticks, walks the channels one per cycle.
// Depends on mspwm_pkg.
module mspwm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  mspwm_pkg::item_t q_item,
  output logic             pop,
  input  logic [15:0]      blink_period,
  input  logic [15:0]      blink_off_at,
  input  logic [31:0]      invert_mask,
  input  logic [31:0]      night_mask,
  input  logic [31:0]      safety_mask,
  input  logic [15:0]      safety_limit,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tuser,
  output logic             busy
);
  import mspwm_pkg::*;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [CHANNELS-1:0] en_r, en_nxt;
  logic [7:0] mode_r [CHANNELS];
  logic [15:0] tmr_r [CHANNELS];
  logic [5:0] lvl_r [CHANNELS];
  logic [1:0] bank_r, bank_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [15:0] phase_r, phase_nxt, blink_r, blink_nxt;
  logic [9:0] step_r, step_nxt;
  logic [2:0] milli_r, milli_nxt;
  logic health_r, health_nxt, night_r, night_nxt;
  logic ov_r, ov_nxt;
  logic [31:0] pins_r, pins_nxt;
  logic hl_r, hl_nxt;
  logic emit;

  // channel-walk per-channel values
  logic [CHANNELS-1:0] cbit;
  logic en_w, cut_w, en_after;
  logic [15:0] tmr_inc;
  logic [5:0] lvl_w;
  logic [2:0] spd;
  logic [15:0] period;
  logic [CHANNELS-1:0] pin_vec;

  assign busy = (st_r != ST_IDLE) || ov_r;
  assign pop = q_valid && (st_r == ST_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = pins_r;
  assign out_tuser = hl_r;

  always_comb begin
    cbit = '0;
    cbit[ch_r] = 1'b1;
    en_w = en_r[ch_r];
    tmr_inc = (tmr_r[ch_r] == 16'hFFFF) ? tmr_r[ch_r] : tmr_r[ch_r] + 16'd1;
    cut_w = (safety_limit != 16'd0) && ((safety_mask & cbit) != '0) && en_w;
    en_after = en_w && !(cut_w && tmr_inc >= safety_limit);
    lvl_w = (!en_after || (night_r && (night_mask & cbit) != '0)) ? 6'd0
            : mode_level(mode_r[ch_r], phase_r);
    spd = (q_item.bytes[47:43] != 5'd0) ? 3'd7
          : (q_item.bytes[42:40] == 3'd0) ? 3'd1 : q_item.bytes[42:40];
    period = (blink_period == 16'd0) ? 16'd1 : blink_period;
    for (int c = 0; c < CHANNELS; c++) pin_vec[c] = {1'b0, lvl_r[c]} > cnt_r;
  end

  always_comb begin
    st_nxt = st_r; ch_nxt = ch_r; en_nxt = en_r; bank_nxt = bank_r;
    cnt_nxt = cnt_r; phase_nxt = phase_r; step_nxt = step_r;
    milli_nxt = milli_r; blink_nxt = blink_r; health_nxt = health_r;
    night_nxt = night_r; emit = 1'b0;
    unique case (st_r)
      ST_IDLE: if (pop) begin
        if (q_item.is_tick) begin
          if (milli_r >= 3'd4) begin
            milli_nxt = 3'd0;
            blink_nxt = (blink_r + 16'd1 >= period) ? 16'd0 : blink_r + 16'd1;
            if (blink_nxt == 16'd0) health_nxt = 1'b1;
            else if (blink_nxt == blink_off_at) health_nxt = 1'b0;
          end else milli_nxt = milli_r + 3'd1;
          if (cnt_r == 7'd0 || cnt_r > 7'd48) begin
            cnt_nxt = 7'd48;
            phase_nxt = phase_r + {6'd0, step_r};
            night_nxt = q_item.night;
            ch_nxt = '0;
            st_nxt = ST_WALK;
          end else begin
            cnt_nxt = cnt_r - 7'd1;
            st_nxt = ST_EMIT;
          end
        end else if (q_item.bytes[7:0] == STATE_MARK) begin
          for (int c = 0; c < CHANNELS; c++) en_nxt[c] = q_item.bytes[8 + c];
          step_nxt = {spd, 7'd0};
          bank_nxt = 2'd0;
          st_nxt = ST_EMIT;
        end else begin
          bank_nxt = bank_r + 2'd1;
          st_nxt = ST_EMIT;
        end
      end
      ST_WALK: begin
        en_nxt[ch_r] = en_after;
        if (ch_r == CH_W'(CHANNELS - 1)) st_nxt = ST_EMIT;
        else ch_nxt = ch_r + CH_W'(1);
      end
      ST_EMIT: begin
        emit = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    ov_nxt = emit ? 1'b1 : (ov_r && !out_tready);
    pins_nxt = emit ? ((32'(pin_vec)) ^ invert_mask) & 32'(~(CHANNELS)'(0)) : pins_r;
    hl_nxt = emit ? health_r : hl_r;
  end

  // per-channel arrays: mode, safety timer and level, all cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mode_r[c] <= 8'd0; tmr_r[c] <= 16'd0; lvl_r[c] <= 6'd0;
      end
    end else if (pop && !q_item.is_tick) begin
      if (q_item.bytes[7:0] == STATE_MARK) begin
        for (int c = 0; c < CHANNELS; c++)
          if (q_item.bytes[8 + c] && !en_r[c]) tmr_r[c] <= 16'd0;
      end else begin
        for (int i = 0; i < 8; i++)
          if ({3'd0, bank_r} * 5'd8 + 5'(i) < 6'(CHANNELS))
            mode_r[CH_W'({3'd0, bank_r} * 5'd8 + 5'(i))] <= q_item.bytes[8*i +: 8];
      end
    end else if (st_r == ST_WALK) begin
      if (cut_w) tmr_r[ch_r] <= (tmr_inc >= safety_limit) ? 16'd0 : tmr_inc;
      lvl_r[ch_r] <= lvl_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ch_r <= '0; en_r <= '0; bank_r <= 2'd0; cnt_r <= 7'd0;
      phase_r <= 16'd0; step_r <= 10'd256; milli_r <= 3'd0; blink_r <= 16'd0;
      health_r <= 1'b0; night_r <= 1'b0; ov_r <= 1'b0; pins_r <= '0; hl_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ch_r <= ch_nxt; en_r <= en_nxt; bank_r <= bank_nxt;
      cnt_r <= cnt_nxt; phase_r <= phase_nxt; step_r <= step_nxt;
      milli_r <= milli_nxt; blink_r <= blink_nxt; health_r <= health_nxt;
      night_r <= night_nxt; ov_r <= ov_nxt; pins_r <= pins_nxt; hl_r <= hl_nxt;
    end
  end
endmodule

// File: rtl/multichannel_soft_pwm_waveform_driver.sv
// Soft-PWM driver, 32 channels, with heartbeat LED.
// Messages and non-wrap ticks pass from idle through the emit state; wrap ticks first
// walk the channels one per cycle for safety cutoff and level update.
// A new word is taken only once the last result has left; a two-word queue buffers input.
// Reset: synchronous active-low rst_n empties the queue, clears the back-end state and loads register defaults.
// Depends on mspwm_pkg, mspwm_front, mspwm_back.
module multichannel_soft_pwm_waveform_driver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // msg_byte0 .. msg_byte7
  input  logic [1:0]  in_tuser,  // opcode, night_mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // pin_levels
  output logic        out_tuser, // health_led
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mspwm_pkg::*;
  logic q_valid, pop, busy;
  item_t q_item;
  logic [15:0] period_r, off_r, limit_r;
  logic [31:0] inv_r, night_r, safe_r;

  // register writes only while no word is queued or being worked on
  assign cfg_ready = !busy && !q_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1600; off_r <= 16'd800; limit_r <= 16'd100;
      inv_r <= '0; night_r <= '0; safe_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PERIOD: period_r <= cfg_data[15:0];
        REG_OFF_AT: off_r <= cfg_data[15:0];
        REG_INVERT: inv_r <= cfg_data;
        REG_NIGHT: night_r <= cfg_data;
        REG_SAFE_MASK: safe_r <= cfg_data;
        REG_SAFE_LIM: limit_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mspwm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .pop, .q_valid, .q_item
  );

  mspwm_back u_back (
    .clk, .rst_n, .q_valid, .q_item, .pop,
    .blink_period(period_r), .blink_off_at(off_r), .invert_mask(inv_r),
    .night_mask(night_r), .safety_mask(safe_r), .safety_limit(limit_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .busy
  );
endmodule

// File: rtl/mspwm_checker.sv
// Port-level checker for the soft-PWM driver, bound to the top level.
// Depends on multichannel_soft_pwm_waveform_driver ports only.
module mspwm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  // nothing shows straight out of reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");
  // an offered result word carries known bits
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !$isunknown({out_tdata, out_tuser}))
    else $error("result word has unknown bits");
endmodule

bind multichannel_soft_pwm_waveform_driver mspwm_checker u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

// File: tb/sv/mspwm_watch.sv
// Watcher for the soft-PWM driver: follows the config, input and result channels,
// predicts each result word and compares it. Depends on mspwm_pkg.
module mspwm_watch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  import mspwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] pins;
    logic        led;
  } pin_word_t;

  pin_word_t expected_words[$];
  int        fail_cnt;

  // register copies
  logic [15:0] period_r, off_at_r, limit_r;
  logic [31:0] invert_r, night_r, safe_r;

  // channel and timing state
  logic        ena[CHANNELS];
  logic [7:0]  mode[CHANNELS];
  logic [15:0] stimer[CHANNELS];
  logic [5:0]  lvl[CHANNELS];
  logic [1:0]  bank;
  logic [6:0]  cnt;
  logic [15:0] phase, wstep, bphase;
  logic [2:0]  mdiv;
  logic        hled;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_cnt++;
    $display("mismatch: %s got %h expected %h", what, got, want);
  endtask

  function automatic logic [5:0] wave_level(input int c, input logic night);
    logic [7:0]  x;
    logic [13:0] p;
    if (!ena[c]) return 6'd0;
    if (night && night_r[c]) return 6'd0;
    if (mode[c] <= 8'd49) return mode[c][5:0];
    x = phase[15:8];
    case (mode[c])
      MODE_TRI: begin
        if (x[7]) x = 8'd255 - x;
        p = 14'd49 * x;
        return p[12:7];
      end
      MODE_SQR:  return phase[15] ? FULL_LEVEL : 6'd0;
      MODE_FALL: begin
        p = 14'd49 * (8'd255 - x);
        return p[13:8];
      end
      MODE_RISE: begin
        p = 14'd49 * x;
        return p[13:8];
      end
      default: return 6'd0;
    endcase
  endfunction

  // advance the predicted state by one word and form its pin word
  task automatic apply_word(input logic [63:0] d, input logic tick, input logic night,
                            output pin_word_t w);
    logic [15:0] per;
    logic [7:0]  b, spd;
    per = (period_r == 16'd0) ? 16'd1 : period_r;
    if (tick) begin
      mdiv = mdiv + 3'd1;
      if (mdiv >= 3'd5) begin
        mdiv = 3'd0;
        bphase = bphase + 16'd1;
        if (bphase >= per) bphase = 16'd0;
        if (bphase == 16'd0) hled = 1'b1;
        else if (bphase == off_at_r) hled = 1'b0;
      end
      if (cnt == 7'd0 || cnt > 7'd48) begin
        cnt = 7'd48;
        phase = phase + wstep;
        for (int c = 0; c < CHANNELS; c++) begin
          if (limit_r != 16'd0 && safe_r[c] && ena[c]) begin
            if (stimer[c] != 16'hFFFF) stimer[c]++;
            if (stimer[c] >= limit_r) begin
              ena[c] = 1'b0;
              stimer[c] = 16'd0;
            end
          end
        end
        for (int c = 0; c < CHANNELS; c++) lvl[c] = wave_level(c, night);
      end else begin
        cnt = cnt - 7'd1;
      end
    end else if (d[7:0] == STATE_MARK) begin
      for (int k = 0; k < 4; k++) begin
        b = d[8*(k+1) +: 8];
        for (int i = 0; i < 8; i++) begin
          if (b[i] && !ena[8*k+i]) stimer[8*k+i] = 16'd0;
          ena[8*k+i] = b[i];
        end
      end
      spd = d[47:40];
      if (spd > 8'd7) spd = 8'd7;
      if (spd == 8'd0) spd = 8'd1;
      wstep = {1'b0, spd, 7'd0};
      bank = 2'd0;
    end else begin
      for (int i = 0; i < 8; i++) mode[8*bank+i] = d[8*i +: 8];
      bank = bank + 2'd1;
    end
    for (int c = 0; c < CHANNELS; c++) w.pins[c] = (lvl[c] > cnt) ^ invert_r[c];
    w.led = hled;
  endtask

  always @(posedge clk) begin
    pin_word_t w, e;
    if (!rst_n) begin
      period_r = 16'd1600; off_at_r = 16'd800; limit_r = 16'd100;
      invert_r = '0; night_r = '0; safe_r = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        ena[c] = 1'b0; mode[c] = '0; stimer[c] = '0; lvl[c] = '0;
      end
      bank = '0; cnt = '0; phase = '0; wstep = 16'd256; mdiv = '0; bphase = '0; hled = 1'b0;
      expected_words.delete();
      fail_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PERIOD:    period_r = cfg_data[15:0];
          REG_OFF_AT:    off_at_r = cfg_data[15:0];
          REG_INVERT:    invert_r = cfg_data;
          REG_NIGHT:     night_r  = cfg_data;
          REG_SAFE_MASK: safe_r   = cfg_data;
          REG_SAFE_LIM:  limit_r  = cfg_data[15:0];
          default: ;
        endcase
      end
      // results first, so a result never matches a word accepted on the same edge
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report("unexpected result word", out_tdata, '0);
        end else begin
          e = expected_words.pop_front();
          if (out_tdata !== e.pins) report("pin_levels", out_tdata, e.pins);
          if (out_tuser !== e.led) report("health_led", {31'd0, out_tuser}, {31'd0, e.led});
        end
      end
      if (in_tvalid && in_tready) begin
        apply_word(in_tdata, in_tuser[0], in_tuser[1], w);
        expected_words.push_back(w);
      end
    end
    errors  <= fail_cnt;
    pending <= expected_words.size();
  end
endmodule

// File: tb/sv/testbench.sv
// Top of the soft-PWM driver bench: clock, reset, config writes, input words and
// receiver stalls; mspwm_watch does the checking. Depends on mspwm_pkg, mspwm_watch.
module testbench;
  import mspwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_MSG  = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam int   LIMIT   = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid, out_tready = 1'b0, out_tuser;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0, cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          hold_req = 0, hold_seen = 0, hold_left = 0;
  int          cycles = 0;
  logic        night = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multichannel_soft_pwm_waveform_driver u_top (.*);

  mspwm_watch u_watch (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(input logic op, input logic [63:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    if ($urandom_range(9) == 0) night = ~night;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= {night, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] per, input logic [15:0] off,
                          input logic [31:0] inv, input logic [31:0] ngt,
                          input logic [31:0] sm, input logic [15:0] lim);
    cfg_write(REG_PERIOD, {16'd0, per});
    cfg_write(REG_OFF_AT, {16'd0, off});
    cfg_write(REG_INVERT, inv);
    cfg_write(REG_NIGHT, ngt);
    cfg_write(REG_SAFE_MASK, sm);
    cfg_write(REG_SAFE_LIM, {16'd0, lim});
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_mode;
    case ($urandom_range(3))
      0: return 8'($urandom_range(49));
      1: return 8'($urandom_range(132, 129));
      default: return 8'($urandom);
    endcase
  endfunction

  // one random word: mostly ticks, some state and profile messages
  task automatic random_word;
    logic [63:0] d;
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      send_word(OP_TICK, {$urandom, $urandom});
    end else if (r < 88) begin
      d = {$urandom, $urandom};
      d[7:0] = STATE_MARK;
      if ($urandom_range(1)) d[47:40] = 8'($urandom_range(8));
      send_word(OP_MSG, d);
    end else begin
      for (int i = 0; i < 8; i++) d[8*i +: 8] = pick_mode();
      if (d[7:0] == STATE_MARK) d[7:0] = 8'd65;
      send_word(OP_MSG, d);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings but a night mask, all modes, speed clamps, a few wraps
    set_regs(16'd1600, 16'd800, 32'h0, 32'h0000_FFFF, 32'h0, 16'd100);
    send_word(OP_MSG, {16'h0, 8'd0, 8'h55, 8'hAA, 8'h00, 8'hFF, STATE_MARK});
    send_word(OP_MSG, {8'd255, 8'd132, 8'd131, 8'd130, 8'd129, 8'd50, 8'd49, 8'd0});
    send_word(OP_MSG, {8'd132, 8'd131, 8'd130, 8'd129, 8'd25, 8'd1, 8'd48, 8'd49});
    send_word(OP_MSG, {8'd130, 8'd129, 8'd132, 8'd131, 8'd49, 8'd200, 8'd7, 8'd130});
    send_word(OP_MSG, {8'd129, 8'd130, 8'd131, 8'd132, 8'd0, 8'd49, 8'd128, 8'd64});
    send_word(OP_MSG, {16'hFFFF, 8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, STATE_MARK});
    for (int i = 0; i < 60; i++) send_word(OP_TICK, '0);
    send_word(OP_MSG, {16'h0, 8'd9, 8'hF0, 8'h0F, 8'h33, 8'hCC, STATE_MARK});
    for (int i = 0; i < 60; i++) send_word(OP_TICK, {64{1'b1}});
    drain();

    // no idling
    set_regs(16'd3, 16'd1, 32'h0, 32'h0, 32'h0, 16'd100);
    for (int i = 0; i < 110; i++) random_word();
    drain();

    // sender idle half the time, cutoff at every wrap
    send_idle_pct = 50;
    set_regs(16'd1, 16'd0, 32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, 16'd1);
    for (int i = 0; i < 110; i++) random_word();
    drain();

    // receiver stalling, zero period and zero limit
    send_idle_pct = 0;
    recv_stall_pct = 50;
    set_regs(16'd0, 16'hFFFF, $urandom, 32'hFFFF_FFFF, $urandom, 16'd0);
    for (int i = 0; i < 110; i++) random_word();
    drain();

    // both idling, long hold-off and a full pause
    send_idle_pct = 30;
    recv_stall_pct = 30;
    set_regs(16'hFFFF, 16'd2, $urandom, $urandom, $urandom, 16'd2);
    hold_req++;
    for (int i = 0; i < 75; i++) random_word();
    drain();
    for (int i = 0; i < 75; i++) random_word();
    drain();
    set_regs(16'd4, 16'd2, 32'h0, $urandom, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 40; i++) random_word();
    drain();

    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/mspwm_pkg.sv
rtl/mspwm_front.sv
rtl/mspwm_back.sv
rtl/multichannel_soft_pwm_waveform_driver.sv
rtl/mspwm_checker.sv
tb/sv/mspwm_watch.sv
tb/sv/testbench.sv
